// ===== rtl/cpao_pkg.sv =====
// ----------------------------------------------------------------------------
// Cylinder pair overlap: shared package
// Word formats on both channels, the queued test job, and fixed widths.
// ----------------------------------------------------------------------------
package cpao_pkg;

	// Coordinates and directions are Q7.8 two's complement.
	localparam int COORD_BITS  = 16;
	localparam int RADIUS_BITS = COORD_BITS - 1;
	// Width of one limb of the shared limb multiplier.
	localparam int LIMB_BITS   = 16;

	typedef struct packed {
		logic                          kind;
		logic signed [COORD_BITS-1:0]  point_x;
		logic signed [COORD_BITS-1:0]  point_y;
		logic signed [COORD_BITS-1:0]  point_z;
		logic signed [COORD_BITS-1:0]  dir_x;
		logic signed [COORD_BITS-1:0]  dir_y;
		logic signed [COORD_BITS-1:0]  dir_z;
		logic        [RADIUS_BITS-1:0] radius;
	} in_word_t;

	typedef struct packed {
		logic overlap;
		logic axes_parallel;
	} out_word_t;

	// Kind codes of an input word.
	localparam logic KIND_STORE = 1'b0;
	localparam logic KIND_TEST  = 1'b1;

	// One pair test: held direction a, new direction b, point difference q
	// (held minus new) and the radius sum. Index 0 is x, 1 is y, 2 is z.
	typedef struct packed {
		logic [2:0][COORD_BITS-1:0] a;
		logic [2:0][COORD_BITS-1:0] b;
		logic [2:0][COORD_BITS:0]   q;
		logic [COORD_BITS-1:0]      rsum;
	} job_t;

endpackage

// ===== rtl/cpao_front.sv =====
// ----------------------------------------------------------------------------
// Cylinder pair overlap: front end
// Accepts input words, holds the first cylinder of a pair and turns every
// test word into a job for the queue.
// ----------------------------------------------------------------------------
module cpao_front import cpao_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  in_word_t in_data,
	output logic     job_valid,
	input  logic     job_ready,
	output job_t     job
);

	logic [2:0][COORD_BITS-1:0] held_point_q;
	logic [2:0][COORD_BITS-1:0] held_dir_q;
	logic [RADIUS_BITS-1:0]     held_radius_q;
	logic [2:0][COORD_BITS-1:0] new_point;
	logic                       accept;

	assign in_ready  = job_ready;
	assign accept    = in_valid && in_ready;
	assign job_valid = accept && (in_data.kind == KIND_TEST);

	assign new_point[0] = in_data.point_x;
	assign new_point[1] = in_data.point_y;
	assign new_point[2] = in_data.point_z;

	always_comb begin
		job.a[0] = held_dir_q[0];
		job.a[1] = held_dir_q[1];
		job.a[2] = held_dir_q[2];
		job.b[0] = in_data.dir_x;
		job.b[1] = in_data.dir_y;
		job.b[2] = in_data.dir_z;
		for (int k = 0; k < 3; k++) begin
			job.q[k] = {held_point_q[k][COORD_BITS-1], held_point_q[k]}
				- {new_point[k][COORD_BITS-1], new_point[k]};
		end
		job.rsum = {1'b0, held_radius_q} + {1'b0, in_data.radius};
	end

	// A store word replaces the held cylinder; a test word leaves it alone.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_point_q  <= '0;
			held_dir_q    <= '0;
			held_radius_q <= '0;
		end else if (accept && (in_data.kind == KIND_STORE)) begin
			held_point_q  <= new_point;
			held_dir_q[0] <= in_data.dir_x;
			held_dir_q[1] <= in_data.dir_y;
			held_dir_q[2] <= in_data.dir_z;
			held_radius_q <= in_data.radius;
		end
	end

endmodule

// ===== rtl/cpao_fifo.sv =====
// ----------------------------------------------------------------------------
// Cylinder pair overlap: job queue
// A short first-in first-out queue of test jobs between front and back end.
// ----------------------------------------------------------------------------
module cpao_fifo import cpao_pkg::*; #(
	parameter int DEPTH = 2
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_ready,
	input  job_t push_data,
	output logic pop_valid,
	input  logic pop_ready,
	output job_t pop_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	job_t             slots_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = slots_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/cpao_back.sv =====
// ----------------------------------------------------------------------------
// Cylinder pair overlap: back end
// Runs one job through a fixed program of multiply-accumulate steps on a
// shared limb multiplier and delivers the result word.
// ----------------------------------------------------------------------------
module cpao_back import cpao_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      job_valid,
	output logic      job_ready,
	input  job_t      job,
	output logic      out_valid,
	input  logic      out_ready,
	output out_word_t out_data
);

	localparam int C      = COORD_BITS;
	localparam int L      = LIMB_BITS;
	localparam int N_W    = 2 * C;          // |n| magnitude
	localparam int D_W    = 3 * C + 1;      // |n.q| magnitude
	localparam int NN_W   = 4 * C;          // |n|^2
	localparam int R2_W   = 2 * C + 1;      // (r1+r2)^2
	localparam int VW     = 4 * C;          // widest operand
	localparam int NL     = (VW + L - 1) / L;
	localparam int VWP    = NL * L;
	localparam int ACC_W  = 6 * C + 3;
	localparam int CNT_W  = $clog2(NL + 1);
	localparam int IDX_W  = $clog2(NL);
	localparam int SH_W   = $clog2(2 * NL - 1);
	localparam int LA     = (C + L - 1) / L;
	localparam int LQ     = (C + 1 + L - 1) / L;
	localparam int LN     = (N_W + L - 1) / L;
	localparam int LD     = (D_W + L - 1) / L;
	localparam int LNN    = (NN_W + L - 1) / L;
	localparam int LR     = (C + 1 + L - 1) / L;
	localparam int LR2    = (R2_W + L - 1) / L;

	typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_CHECK, ST_FINISH} state_t;

	typedef enum logic [3:0] {
		SL_A0, SL_A1, SL_A2, SL_B0, SL_B1, SL_B2, SL_N0, SL_N1,
		SL_N2, SL_Q0, SL_Q1, SL_Q2, SL_DOT, SL_NN, SL_RS, SL_RS2
	} slot_t;

	typedef struct packed {
		slot_t x;
		slot_t y;
		logic  sub;
		logic  clr;
		logic  wr;
		slot_t dst;
	} step_t;

	// The step after which the cross product is complete, and the final step.
	localparam logic [3:0] CHECK_STEP = 4'd5;
	localparam logic [3:0] LAST_STEP  = 4'd14;

	function automatic step_t mk(input slot_t x, input slot_t y, input logic sub,
			input logic clr, input logic wr, input slot_t dst);
		step_t s;
		s.x   = x;
		s.y   = y;
		s.sub = sub;
		s.clr = clr;
		s.wr  = wr;
		s.dst = dst;
		return s;
	endfunction

	// Program: n = a x b, dot = n.q, nn = n.n, rs2 = rsum^2,
	// then acc = dot^2 - rs2 * nn.
	function automatic step_t prog(input logic [3:0] idx);
		step_t s;
		case (idx)
			4'd0:    s = mk(SL_A1,  SL_B2,  1'b0, 1'b1, 1'b0, SL_N0);
			4'd1:    s = mk(SL_A2,  SL_B1,  1'b1, 1'b0, 1'b1, SL_N0);
			4'd2:    s = mk(SL_A2,  SL_B0,  1'b0, 1'b1, 1'b0, SL_N1);
			4'd3:    s = mk(SL_A0,  SL_B2,  1'b1, 1'b0, 1'b1, SL_N1);
			4'd4:    s = mk(SL_A0,  SL_B1,  1'b0, 1'b1, 1'b0, SL_N2);
			4'd5:    s = mk(SL_A1,  SL_B0,  1'b1, 1'b0, 1'b1, SL_N2);
			4'd6:    s = mk(SL_N0,  SL_Q0,  1'b0, 1'b1, 1'b0, SL_DOT);
			4'd7:    s = mk(SL_N1,  SL_Q1,  1'b0, 1'b0, 1'b0, SL_DOT);
			4'd8:    s = mk(SL_N2,  SL_Q2,  1'b0, 1'b0, 1'b1, SL_DOT);
			4'd9:    s = mk(SL_N0,  SL_N0,  1'b0, 1'b1, 1'b0, SL_NN);
			4'd10:   s = mk(SL_N1,  SL_N1,  1'b0, 1'b0, 1'b0, SL_NN);
			4'd11:   s = mk(SL_N2,  SL_N2,  1'b0, 1'b0, 1'b1, SL_NN);
			4'd12:   s = mk(SL_RS,  SL_RS,  1'b0, 1'b1, 1'b1, SL_RS2);
			4'd13:   s = mk(SL_DOT, SL_DOT, 1'b0, 1'b1, 1'b0, SL_DOT);
			4'd14:   s = mk(SL_RS2, SL_NN,  1'b1, 1'b0, 1'b0, SL_DOT);
			default: s = mk(SL_RS,  SL_RS,  1'b0, 1'b1, 1'b0, SL_DOT);
		endcase
		return s;
	endfunction

	function automatic logic [CNT_W-1:0] limbs(input slot_t s);
		logic [CNT_W-1:0] n;
		case (s) inside
			SL_A0, SL_A1, SL_A2, SL_B0, SL_B1, SL_B2: n = CNT_W'(LA);
			SL_N0, SL_N1, SL_N2:                      n = CNT_W'(LN);
			SL_Q0, SL_Q1, SL_Q2:                      n = CNT_W'(LQ);
			SL_DOT:                                   n = CNT_W'(LD);
			SL_NN:                                    n = CNT_W'(LNN);
			SL_RS:                                    n = CNT_W'(LR);
			default:                                  n = CNT_W'(LR2);
		endcase
		return n;
	endfunction

	function automatic logic [C:0] sm_abs(input logic [C:0] v);
		return v[C] ? (~v + 1'b1) : v;
	endfunction

	state_t           state_q;
	job_t             job_q;
	logic [3:0]       step_q;
	logic [IDX_W-1:0] li_q;
	logic [IDX_W-1:0] lj_q;
	logic [ACC_W-1:0] acc_q;
	logic [N_W-1:0]   n_mag_q [3];
	logic             n_sgn_q [3];
	logic [D_W-1:0]   dot_q;
	logic [NN_W-1:0]  nn_q;
	logic [R2_W-1:0]  rs2_q;
	logic             ovl_q;
	logic             par_q;
	logic             out_valid_q;
	out_word_t        out_q;

	step_t            cur;
	slot_t            sel [2];
	logic [VWP-1:0]   op_mag [2];
	logic             op_sgn [2];
	logic [L-1:0]     x_limb;
	logic [L-1:0]     y_limb;
	logic [2*L-1:0]   pp;
	logic [SH_W-1:0]  sh;
	logic [ACC_W-1:0] shifted;
	logic [ACC_W-1:0] addend;
	logic [ACC_W-1:0] base;
	logic [ACC_W-1:0] acc_d;
	logic [ACC_W-1:0] acc_abs;
	logic             neg;
	logic             last_i;
	logic             last_j;
	logic             overlap_d;
	logic             n_zero;
	logic             out_load;

	assign cur       = prog(step_q);
	assign job_ready = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	// The output register takes a new word when it is empty or being drained.
	assign out_load  = (state_q == ST_FINISH) && (!out_valid_q || out_ready);

	// Operand fetch as sign and magnitude.
	always_comb begin
		sel[0] = cur.x;
		sel[1] = cur.y;
		for (int k = 0; k < 2; k++) begin
			op_mag[k] = '0;
			op_sgn[k] = 1'b0;
			case (sel[k])
				SL_A0: begin
					op_mag[k] = VWP'(sm_abs({job_q.a[0][C-1], job_q.a[0]}));
					op_sgn[k] = job_q.a[0][C-1];
				end
				SL_A1: begin
					op_mag[k] = VWP'(sm_abs({job_q.a[1][C-1], job_q.a[1]}));
					op_sgn[k] = job_q.a[1][C-1];
				end
				SL_A2: begin
					op_mag[k] = VWP'(sm_abs({job_q.a[2][C-1], job_q.a[2]}));
					op_sgn[k] = job_q.a[2][C-1];
				end
				SL_B0: begin
					op_mag[k] = VWP'(sm_abs({job_q.b[0][C-1], job_q.b[0]}));
					op_sgn[k] = job_q.b[0][C-1];
				end
				SL_B1: begin
					op_mag[k] = VWP'(sm_abs({job_q.b[1][C-1], job_q.b[1]}));
					op_sgn[k] = job_q.b[1][C-1];
				end
				SL_B2: begin
					op_mag[k] = VWP'(sm_abs({job_q.b[2][C-1], job_q.b[2]}));
					op_sgn[k] = job_q.b[2][C-1];
				end
				SL_N0: begin
					op_mag[k] = VWP'(n_mag_q[0]);
					op_sgn[k] = n_sgn_q[0];
				end
				SL_N1: begin
					op_mag[k] = VWP'(n_mag_q[1]);
					op_sgn[k] = n_sgn_q[1];
				end
				SL_N2: begin
					op_mag[k] = VWP'(n_mag_q[2]);
					op_sgn[k] = n_sgn_q[2];
				end
				SL_Q0: begin
					op_mag[k] = VWP'(sm_abs(job_q.q[0]));
					op_sgn[k] = job_q.q[0][C];
				end
				SL_Q1: begin
					op_mag[k] = VWP'(sm_abs(job_q.q[1]));
					op_sgn[k] = job_q.q[1][C];
				end
				SL_Q2: begin
					op_mag[k] = VWP'(sm_abs(job_q.q[2]));
					op_sgn[k] = job_q.q[2][C];
				end
				SL_DOT: op_mag[k] = VWP'(dot_q);
				SL_NN:  op_mag[k] = VWP'(nn_q);
				SL_RS:  op_mag[k] = VWP'(job_q.rsum);
				SL_RS2: op_mag[k] = VWP'(rs2_q);
				default: op_mag[k] = '0;
			endcase
		end
	end

	// One limb product per cycle in the run state, shifted into place and accumulated.
	always_comb begin
		x_limb    = op_mag[0][L*li_q +: L];
		y_limb    = op_mag[1][L*lj_q +: L];
		pp        = x_limb * y_limb;
		sh        = SH_W'(li_q) + SH_W'(lj_q);
		shifted   = ACC_W'(pp) << (L * sh);
		neg       = op_sgn[0] ^ op_sgn[1] ^ cur.sub;
		addend    = neg ? (~shifted + 1'b1) : shifted;
		base      = (cur.clr && (li_q == '0) && (lj_q == '0)) ? '0 : acc_q;
		acc_d     = base + addend;
		acc_abs   = acc_d[ACC_W-1] ? (~acc_d + 1'b1) : acc_d;
		overlap_d = acc_d[ACC_W-1] || (acc_d == '0);
		last_i    = ((CNT_W'(li_q) + 1'b1) == limbs(cur.x));
		last_j    = ((CNT_W'(lj_q) + 1'b1) == limbs(cur.y));
		n_zero    = (n_mag_q[0] == '0) && (n_mag_q[1] == '0) && (n_mag_q[2] == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			job_q       <= '0;
			step_q      <= '0;
			li_q        <= '0;
			lj_q        <= '0;
			acc_q       <= '0;
			n_mag_q     <= '{default: '0};
			n_sgn_q     <= '{default: 1'b0};
			dot_q       <= '0;
			nn_q        <= '0;
			rs2_q       <= '0;
			ovl_q       <= 1'b0;
			par_q       <= 1'b0;
			out_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (job_valid) begin
						job_q   <= job;
						step_q  <= '0;
						li_q    <= '0;
						lj_q    <= '0;
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					acc_q <= acc_d;
					if (last_j) begin
						lj_q <= '0;
						if (last_i) begin
							li_q <= '0;
							if (cur.wr) begin
								case (cur.dst)
									SL_N0: begin
										n_mag_q[0] <= acc_abs[N_W-1:0];
										n_sgn_q[0] <= acc_d[ACC_W-1];
									end
									SL_N1: begin
										n_mag_q[1] <= acc_abs[N_W-1:0];
										n_sgn_q[1] <= acc_d[ACC_W-1];
									end
									SL_N2: begin
										n_mag_q[2] <= acc_abs[N_W-1:0];
										n_sgn_q[2] <= acc_d[ACC_W-1];
									end
									SL_DOT:  dot_q <= acc_abs[D_W-1:0];
									SL_NN:   nn_q  <= acc_abs[NN_W-1:0];
									SL_RS2:  rs2_q <= acc_abs[R2_W-1:0];
									default: ;
								endcase
							end
							if (step_q == LAST_STEP) begin
								ovl_q   <= overlap_d;
								par_q   <= 1'b0;
								state_q <= ST_FINISH;
							end else if (step_q == CHECK_STEP) begin
								step_q  <= step_q + 1'b1;
								state_q <= ST_CHECK;
							end else begin
								step_q <= step_q + 1'b1;
							end
						end else begin
							li_q <= li_q + 1'b1;
						end
					end else begin
						lj_q <= lj_q + 1'b1;
					end
				end
				ST_CHECK: begin
					// A zero cross product means parallel axes: no overlap.
					if (n_zero) begin
						ovl_q   <= 1'b0;
						par_q   <= 1'b1;
						state_q <= ST_FINISH;
					end else begin
						state_q <= ST_RUN;
					end
				end
				ST_FINISH: begin
					if (out_load) begin
						out_q.overlap       <= ovl_q;
						out_q.axes_parallel <= par_q;
						state_q             <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== rtl/cylinder_pair_axis_overlap.sv =====
// ----------------------------------------------------------------------------
// Cylinder pair overlap test
// Tests two infinite cylinders for overlap of their axis distance against
// the sum of their radii, exactly and without roots or division.
// ----------------------------------------------------------------------------
// Usage: the input channel (in_valid, in_ready, in_data) carries one cylinder
// per word. A word of kind 0 becomes the held first cylinder and gives no
// result. A word of kind 1 is tested against the held cylinder and gives one
// result word on the output channel (out_valid, out_ready, out_data).
// Store words are taken one per cycle while the job queue has room; test
// words are queued, so the front keeps accepting while the back end works.
// The back end runs one test at a time through a shared 16 x 16 limb
// multiplier, one limb product per cycle. A test is loaded from the queue,
// runs its multiply steps with a zero check on the cross product between
// them, and ends in the output register; parallel axes end after the cross
// product. The back end takes a new test only once its last result has
// gone into the output register.
// Reset clears the held cylinder to zero (a test before any store reports
// parallel axes), empties the queue and drops any pending result. When the
// receiver stalls, the result waits in the output register, the back end
// holds its next result, and the queue fills before in_ready falls.
// ----------------------------------------------------------------------------
module cylinder_pair_axis_overlap import cpao_pkg::*; #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_word_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_word_t out_data
);

	// Front end to queue.
	logic job_push_valid;
	logic job_push_ready;
	job_t job_push;

	// Queue to back end.
	logic job_pop_valid;
	logic job_pop_ready;
	job_t job_pop;

	cpao_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.job_valid (job_push_valid),
		.job_ready (job_push_ready),
		.job       (job_push)
	);

	cpao_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (job_push_valid),
		.push_ready (job_push_ready),
		.push_data  (job_push),
		.pop_valid  (job_pop_valid),
		.pop_ready  (job_pop_ready),
		.pop_data   (job_pop)
	);

	// The back end owns the output register, so a stalled receiver holds the
	// back end first; the front and the queue keep moving until the queue fills.
	cpao_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (job_pop_valid),
		.job_ready (job_pop_ready),
		.job       (job_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule
